### rtl/segisp_pkg.sv
// shared types and constants for the segment intersection pipeline
// no dependencies; used by segment_intersection_point
package segisp_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;

	typedef enum logic [1:0] {
		OUT_CROSS    = 2'd0,
		OUT_PARALLEL = 2'd1,
		OUT_OUTSIDE  = 2'd2
	} outcome_t;

	typedef struct packed {
		logic signed [15:0] a_start_x;
		logic signed [15:0] a_start_y;
		logic signed [15:0] a_end_x;
		logic signed [15:0] a_end_y;
		logic signed [15:0] b_start_x;
		logic signed [15:0] b_start_y;
		logic signed [15:0] b_end_x;
		logic signed [15:0] b_end_y;
	} seg_pair_t;

	typedef struct packed {
		outcome_t           outcome;
		logic signed [31:0] cross_x;
		logic signed [31:0] cross_y;
	} cross_res_t;

endpackage

### rtl/segment_intersection_point.sv
// two-segment intersection with exact parameter test and fixed-point crossing point
// depends on segisp_pkg
//
//   channel | signals                        | carries
//   input   | in_valid, in_ready, in_item    | one segment pair (segisp_pkg::seg_pair_t)
//   output  | out_valid, out_ready, out_item | one result (segisp_pkg::cross_res_t)
//
// one pair accepted per cycle while the output is not stalled
// the restoring divider computes one quotient bit per stage
// reset clears only the valid bits; payload registers are not reset
// a stall on the output freezes the whole pipeline, nothing is dropped or repeated
module segment_intersection_point #(
	parameter int COORD_BITS = segisp_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = segisp_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  segisp_pkg::seg_pair_t  in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output segisp_pkg::cross_res_t out_item
);

	localparam int CW = COORD_BITS;
	localparam int DW = CW + 1;
	localparam int PW = 2 * CW + 2;
	localparam int SW = 2 * CW + 3;
	localparam int MW = 2 * CW + 2;
	localparam int NW = 3 * CW + 3;
	localparam int FW = NW + FRAC_BITS;
	localparam int QB = CW + FRAC_BITS;
	localparam int RW = MW + 1;

	logic adv;

	// stage 1: coordinates, direction and offset vectors
	logic signed [CW-1:0] ax_c, ay_c, aex_c, aey_c, bx_c, by_c, bex_c, bey_c;
	logic                 v_s1;
	logic signed [CW-1:0] ax_s1, ay_s1;
	logic signed [DW-1:0] dx1_s1, dy1_s1, dx2_s1, dy2_s1, wx_s1, wy_s1;

	// stage 2: the six cross products
	logic                 v_s2;
	logic signed [CW-1:0] ax_s2, ay_s2;
	logic signed [DW-1:0] dx1_s2, dy1_s2;
	logic signed [PW-1:0] pd1_s2, pd2_s2, pt1_s2, pt2_s2, pu1_s2, pu2_s2;

	// stage 3: den, tn, un
	logic                 v_s3;
	logic signed [CW-1:0] ax_s3, ay_s3;
	logic signed [DW-1:0] dx1_s3, dy1_s3;
	logic signed [SW-1:0] den_s3, tn_s3, un_s3;

	// stage 4: sign normalise and classify
	logic signed [SW-1:0]  den_n, tn_n, un_n;
	segisp_pkg::outcome_t  oc_c;
	logic                  v_s4;
	segisp_pkg::outcome_t  oc_s4;
	logic signed [CW-1:0]  ax_s4, ay_s4;
	logic signed [DW-1:0]  dx1_s4, dy1_s4;
	logic [MW-1:0]         den_s4, tn_s4;

	// stage 5: numerator products
	logic                 v_s5;
	segisp_pkg::outcome_t oc_s5;
	logic [MW-1:0]        den_s5;
	logic signed [NW-1:0] pxo_s5, pxd_s5, pyo_s5, pyd_s5;

	// stage 6: numerator sums
	logic                 v_s6;
	segisp_pkg::outcome_t oc_s6;
	logic [MW-1:0]        den_s6;
	logic signed [NW-1:0] nx_s6, ny_s6;

	// divider pipeline, entry 0 is stage 7
	logic [NW-1:0]        magx_c, magy_c;
	logic [FW-1:0]        shx_c, shy_c;
	logic                 dv_v[0:QB];
	segisp_pkg::outcome_t dv_oc[0:QB];
	logic [MW-1:0]        dv_den[0:QB];
	logic                 dv_negx[0:QB], dv_negy[0:QB];
	logic [RW-1:0]        dv_remx[0:QB], dv_remy[0:QB];
	logic [QB-1:0]        dv_lowx[0:QB], dv_lowy[0:QB];
	logic [QB-1:0]        dv_qx[0:QB], dv_qy[0:QB];

	// output register
	logic                   res_v_q;
	segisp_pkg::cross_res_t res_q;
	logic [31:0]            qx32, qy32;

	assign adv       = !res_v_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = res_v_q;
	assign out_item  = res_q;

	// fields are zero-extended or cut to COORD_BITS, then read as signed
	always_comb begin
		ax_c  = $signed(CW'(unsigned'(in_item.a_start_x)));
		ay_c  = $signed(CW'(unsigned'(in_item.a_start_y)));
		aex_c = $signed(CW'(unsigned'(in_item.a_end_x)));
		aey_c = $signed(CW'(unsigned'(in_item.a_end_y)));
		bx_c  = $signed(CW'(unsigned'(in_item.b_start_x)));
		by_c  = $signed(CW'(unsigned'(in_item.b_start_y)));
		bex_c = $signed(CW'(unsigned'(in_item.b_end_x)));
		bey_c = $signed(CW'(unsigned'(in_item.b_end_y)));
	end

	always_comb begin
		den_n = den_s3[SW-1] ? -den_s3 : den_s3;
		tn_n  = den_s3[SW-1] ? -tn_s3 : tn_s3;
		un_n  = den_s3[SW-1] ? -un_s3 : un_s3;
		if (den_s3 == '0) begin
			oc_c = segisp_pkg::OUT_PARALLEL;
		end else if (tn_n < 0 || tn_n > den_n || un_n < 0 || un_n > den_n) begin
			oc_c = segisp_pkg::OUT_OUTSIDE;
		end else begin
			oc_c = segisp_pkg::OUT_CROSS;
		end
	end

	always_comb begin
		magx_c = nx_s6[NW-1] ? NW'(-nx_s6) : NW'(nx_s6);
		magy_c = ny_s6[NW-1] ? NW'(-ny_s6) : NW'(ny_s6);
		shx_c  = FW'(magx_c) << FRAC_BITS;
		shy_c  = FW'(magy_c) << FRAC_BITS;
	end

	always_comb begin
		qx32 = dv_negx[QB] ? 32'(0) - 32'(dv_qx[QB]) : 32'(dv_qx[QB]);
		qy32 = dv_negy[QB] ? 32'(0) - 32'(dv_qy[QB]) : 32'(dv_qy[QB]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			dv_v[0]   <= 1'b0;
			res_v_q   <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			dv_v[0]   <= v_s6;
			res_v_q   <= dv_v[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1  <= ax_c;
			ay_s1  <= ay_c;
			dx1_s1 <= DW'(aex_c) - DW'(ax_c);
			dy1_s1 <= DW'(aey_c) - DW'(ay_c);
			dx2_s1 <= DW'(bex_c) - DW'(bx_c);
			dy2_s1 <= DW'(bey_c) - DW'(by_c);
			wx_s1  <= DW'(bx_c) - DW'(ax_c);
			wy_s1  <= DW'(by_c) - DW'(ay_c);

			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			dx1_s2 <= dx1_s1;
			dy1_s2 <= dy1_s1;
			pd1_s2 <= PW'(dx1_s1) * PW'(dy2_s1);
			pd2_s2 <= PW'(dy1_s1) * PW'(dx2_s1);
			pt1_s2 <= PW'(wx_s1) * PW'(dy2_s1);
			pt2_s2 <= PW'(wy_s1) * PW'(dx2_s1);
			pu1_s2 <= PW'(wx_s1) * PW'(dy1_s1);
			pu2_s2 <= PW'(wy_s1) * PW'(dx1_s1);

			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			dx1_s3 <= dx1_s2;
			dy1_s3 <= dy1_s2;
			den_s3 <= SW'(pd1_s2) - SW'(pd2_s2);
			tn_s3  <= SW'(pt1_s2) - SW'(pt2_s2);
			un_s3  <= SW'(pu1_s2) - SW'(pu2_s2);

			oc_s4  <= oc_c;
			ax_s4  <= ax_s3;
			ay_s4  <= ay_s3;
			dx1_s4 <= dx1_s3;
			dy1_s4 <= dy1_s3;
			den_s4 <= den_n[MW-1:0];
			tn_s4  <= tn_n[MW-1:0];

			oc_s5  <= oc_s4;
			den_s5 <= den_s4;
			pxo_s5 <= NW'(ax_s4) * $signed(NW'(den_s4));
			pyo_s5 <= NW'(ay_s4) * $signed(NW'(den_s4));
			pxd_s5 <= $signed(NW'(tn_s4)) * NW'(dx1_s4);
			pyd_s5 <= $signed(NW'(tn_s4)) * NW'(dy1_s4);

			oc_s6  <= oc_s5;
			den_s6 <= den_s5;
			nx_s6  <= pxo_s5 + pxd_s5;
			ny_s6  <= pyo_s5 + pyd_s5;

			dv_oc[0]   <= oc_s6;
			dv_den[0]  <= den_s6;
			dv_negx[0] <= nx_s6[NW-1];
			dv_negy[0] <= ny_s6[NW-1];
			dv_remx[0] <= shx_c[FW-1:QB];
			dv_remy[0] <= shy_c[FW-1:QB];
			dv_lowx[0] <= shx_c[QB-1:0];
			dv_lowy[0] <= shy_c[QB-1:0];
			dv_qx[0]   <= '0;
			dv_qy[0]   <= '0;

			res_q.outcome <= dv_oc[QB];
			res_q.cross_x <= (dv_oc[QB] == segisp_pkg::OUT_CROSS) ? $signed(qx32) : '0;
			res_q.cross_y <= (dv_oc[QB] == segisp_pkg::OUT_CROSS) ? $signed(qy32) : '0;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [RW-1:0] rx, ry;
		logic          gex, gey;

		always_comb begin
			rx  = {dv_remx[k][RW-2:0], dv_lowx[k][QB-1]};
			ry  = {dv_remy[k][RW-2:0], dv_lowy[k][QB-1]};
			gex = rx >= {1'b0, dv_den[k]};
			gey = ry >= {1'b0, dv_den[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else if (adv) begin
				dv_v[k+1] <= dv_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_oc[k+1]   <= dv_oc[k];
				dv_den[k+1]  <= dv_den[k];
				dv_negx[k+1] <= dv_negx[k];
				dv_negy[k+1] <= dv_negy[k];
				dv_remx[k+1] <= gex ? rx - {1'b0, dv_den[k]} : rx;
				dv_remy[k+1] <= gey ? ry - {1'b0, dv_den[k]} : ry;
				dv_lowx[k+1] <= dv_lowx[k] << 1;
				dv_lowy[k+1] <= dv_lowy[k] << 1;
				dv_qx[k+1]   <= {dv_qx[k][QB-2:0], gex};
				dv_qy[k+1]   <= {dv_qy[k][QB-2:0], gey};
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_zero_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.outcome != segisp_pkg::OUT_CROSS |->
		out_item.cross_x == '0 && out_item.cross_y == '0)
		else $error("non-crossing result carries a point");

	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && dv_v[QB] |=> out_valid)
		else $error("divider result lost on the way to the output register");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v[QB] && dv_oc[QB] == segisp_pkg::OUT_CROSS |->
		dv_remx[QB] < {1'b0, dv_den[QB]} && dv_remy[QB] < {1'b0, dv_den[QB]})
		else $error("divider remainder not below the divisor");
`endif

endmodule
